// ----- sv/sli_pkg.sv -----
// Shared types for the segment/line crossing block.
// No dependencies.
package sli_pkg;

  // Flags that travel alongside each request through the front stages.
  typedef struct packed {
    logic vld;
    logic strict;
    logic par;
  } ctl_t;

endpackage

// ----- sv/segment_line_intersection.sv -----
// Top level of the segment/line crossing block: exact cross products, sign
// normalization and a pipelined digit divider. Depends on sli_pkg.
//
// Each request carries a segment and two points of an infinite line. With
// d = b - a, the block forms exact cross products d1 = d x (start - a) and
// d2 = d x (end - a). Equal products mean parallel (or degenerate) input:
// parallel = 1, hit = 0, point = 0. Otherwise the crossing counts when
// d1 / (d1 - d2) lies in [0, 1] (strict = 0) or in (0, 1) (strict = 1), and
// the point start + (end - start) * d1 / (d1 - d2) is returned per axis,
// truncated toward zero; without a hit the point is 0. The block takes one
// request per cycle while in_stall is low. From acceptance to a valid result a
// request passes six front stages (differences, products, cross products,
// denominator, sign normalization, range test), COORD_BITS + 1 divider
// stages that each resolve one quotient bit for both axes, and an output
// register. All stages advance together; in_stall rises only while a result
// sits in the output register and the consumer stalls it.
module segment_line_intersection #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_seg_start_x,
  input  logic signed [COORD_BITS-1:0] in_seg_start_y,
  input  logic signed [COORD_BITS-1:0] in_seg_end_x,
  input  logic signed [COORD_BITS-1:0] in_seg_end_y,
  input  logic signed [COORD_BITS-1:0] in_line_a_x,
  input  logic signed [COORD_BITS-1:0] in_line_a_y,
  input  logic signed [COORD_BITS-1:0] in_line_b_x,
  input  logic signed [COORD_BITS-1:0] in_line_b_y,
  input  logic                         in_strict,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic                         out_parallel,
  output logic signed [COORD_BITS-1:0] out_cross_x,
  output logic signed [COORD_BITS-1:0] out_cross_y
);

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;      // coordinate differences
  localparam int PW = 2 * DW;      // products
  localparam int XW = PW + 1;      // cross products
  localparam int NW = XW + 1;      // signed denominator
  localparam int UW = NW - 1;      // normalized magnitudes
  localparam int RW = UW + 2;      // divider remainder
  localparam int QW = CW + 1;      // quotient
  localparam int NS = CW + 2;      // divider stage slots (slot 0 is the range test)

  logic adv;
  logic out_valid_r;

  // Advance the whole pipe unless the output holds a stalled result.
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Stage 1: differences.
  sli_pkg::ctl_t            c1_r;
  logic signed [DW-1:0]     dx_r, dy_r, sax_r, say_r, eax_r, eay_r, delx_r, dely_r;
  logic signed [CW-1:0]     sx1_r, sy1_r;
  // Stage 2: products.
  sli_pkg::ctl_t            c2_r;
  logic signed [PW-1:0]     p1_r, p2_r, p3_r, p4_r;
  logic signed [DW-1:0]     delx2_r, dely2_r;
  logic signed [CW-1:0]     sx2_r, sy2_r;
  // Stage 3: cross products.
  sli_pkg::ctl_t            c3_r;
  logic signed [XW-1:0]     d1_r, d2_r;
  logic signed [DW-1:0]     delx3_r, dely3_r;
  logic signed [CW-1:0]     sx3_r, sy3_r;
  // Stage 4: denominator.
  sli_pkg::ctl_t            c4_r;
  logic signed [XW-1:0]     d1b_r;
  logic signed [NW-1:0]     den_r;
  logic signed [DW-1:0]     delx4_r, dely4_r;
  logic signed [CW-1:0]     sx4_r, sy4_r;
  // Stage 5: sign normalization.
  sli_pkg::ctl_t            c5_r;
  logic signed [NW-1:0]     n1_r, dn_r;
  logic signed [DW-1:0]     delx5_r, dely5_r;
  logic signed [CW-1:0]     sx5_r, sy5_r;

  logic signed [NW-1:0]     den_nxt;

  // Divider slots.
  logic            vld_r  [0:NS-1];
  logic            hit_r  [0:NS-1];
  logic            par_r  [0:NS-1];
  logic            negx_r [0:NS-1];
  logic            negy_r [0:NS-1];
  logic [QW-1:0]   magx_r [0:NS-1];
  logic [QW-1:0]   magy_r [0:NS-1];
  logic [UW-1:0]   num_r  [0:NS-1];
  logic [UW-1:0]   dv_r   [0:NS-1];
  logic [CW-1:0]   sx_r   [0:NS-1];
  logic [CW-1:0]   sy_r   [0:NS-1];
  logic [QW-1:0]   qx_r   [0:NS-1];
  logic [QW-1:0]   qy_r   [0:NS-1];
  logic [RW-1:0]   rx_r   [0:NS-1];
  logic [RW-1:0]   ry_r   [0:NS-1];

  // Output register.
  logic                  out_hit_r, out_par_r;
  logic signed [CW-1:0]  out_x_r, out_y_r;

  assign den_nxt = NW'(d1_r) - NW'(d2_r);

  // Front stages: payload, no reset.
  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r    <= DW'(in_line_b_x) - DW'(in_line_a_x);
      dy_r    <= DW'(in_line_b_y) - DW'(in_line_a_y);
      sax_r   <= DW'(in_seg_start_x) - DW'(in_line_a_x);
      say_r   <= DW'(in_seg_start_y) - DW'(in_line_a_y);
      eax_r   <= DW'(in_seg_end_x) - DW'(in_line_a_x);
      eay_r   <= DW'(in_seg_end_y) - DW'(in_line_a_y);
      delx_r  <= DW'(in_seg_end_x) - DW'(in_seg_start_x);
      dely_r  <= DW'(in_seg_end_y) - DW'(in_seg_start_y);
      sx1_r   <= in_seg_start_x;
      sy1_r   <= in_seg_start_y;

      p1_r    <= dx_r * say_r;
      p2_r    <= dy_r * sax_r;
      p3_r    <= dx_r * eay_r;
      p4_r    <= dy_r * eax_r;
      delx2_r <= delx_r;
      dely2_r <= dely_r;
      sx2_r   <= sx1_r;
      sy2_r   <= sy1_r;

      d1_r    <= XW'(p1_r) - XW'(p2_r);
      d2_r    <= XW'(p3_r) - XW'(p4_r);
      delx3_r <= delx2_r;
      dely3_r <= dely2_r;
      sx3_r   <= sx2_r;
      sy3_r   <= sy2_r;

      d1b_r   <= d1_r;
      den_r   <= den_nxt;
      delx4_r <= delx3_r;
      dely4_r <= dely3_r;
      sx4_r   <= sx3_r;
      sy4_r   <= sy3_r;

      // Flip both signs so the denominator is nonnegative.
      n1_r    <= den_r[NW-1] ? -NW'(d1b_r) : NW'(d1b_r);
      dn_r    <= den_r[NW-1] ? -den_r : den_r;
      delx5_r <= delx4_r;
      dely5_r <= dely4_r;
      sx5_r   <= sx4_r;
      sy5_r   <= sy4_r;
    end
  end

  // Front stages: control. Valid bits reset, the flags just advance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.vld <= 1'b0;
      c2_r.vld <= 1'b0;
      c3_r.vld <= 1'b0;
      c4_r.vld <= 1'b0;
      c5_r.vld <= 1'b0;
    end else if (adv) begin
      c1_r.vld <= in_valid;
      c2_r.vld <= c1_r.vld;
      c3_r.vld <= c2_r.vld;
      c4_r.vld <= c3_r.vld;
      c5_r.vld <= c4_r.vld;
    end
    if (adv) begin
      c1_r.strict <= in_strict;
      c1_r.par    <= 1'b0;
      c2_r.strict <= c1_r.strict;
      c2_r.par    <= 1'b0;
      c3_r.strict <= c2_r.strict;
      c3_r.par    <= 1'b0;
      c4_r.strict <= c3_r.strict;
      c4_r.par    <= (den_nxt == '0);
      c5_r.strict <= c4_r.strict;
      c5_r.par    <= c4_r.par;
    end
  end

  // Slot 0: range test and delta magnitudes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= c5_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      par_r[0]  <= c5_r.par;
      if (c5_r.par) begin
        hit_r[0] <= 1'b0;
      end else if (c5_r.strict) begin
        hit_r[0] <= (n1_r > 0) && (n1_r < dn_r);
      end else begin
        hit_r[0] <= (n1_r >= 0) && (n1_r <= dn_r);
      end
      negx_r[0] <= delx5_r[DW-1];
      negy_r[0] <= dely5_r[DW-1];
      magx_r[0] <= delx5_r[DW-1] ? QW'(-delx5_r) : QW'(delx5_r);
      magy_r[0] <= dely5_r[DW-1] ? QW'(-dely5_r) : QW'(dely5_r);
      num_r[0]  <= n1_r[UW-1:0];
      dv_r[0]   <= dn_r[UW-1:0];
      sx_r[0]   <= sx5_r;
      sy_r[0]   <= sy5_r;
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      rx_r[0]   <= '0;
      ry_r[0]   <= '0;
    end
  end

  // Divider: slot j resolves quotient bit CW+1-j of mag*num/den per axis.
  for (genvar j = 1; j < NS; j++) begin : g_div
    logic [RW-1:0] tx, ty, dd1, dd2;
    logic [1:0]    gx, gy;

    always_comb begin
      dd1 = RW'(dv_r[j-1]);
      dd2 = {dd1[RW-2:0], 1'b0};
      tx  = {rx_r[j-1][RW-2:0], 1'b0} + (magx_r[j-1][CW+1-j] ? RW'(num_r[j-1]) : '0);
      ty  = {ry_r[j-1][RW-2:0], 1'b0} + (magy_r[j-1][CW+1-j] ? RW'(num_r[j-1]) : '0);
      if (tx >= dd2) begin
        gx = 2'd2;
      end else if (tx >= dd1) begin
        gx = 2'd1;
      end else begin
        gx = 2'd0;
      end
      if (ty >= dd2) begin
        gy = 2'd2;
      end else if (ty >= dd1) begin
        gy = 2'd1;
      end else begin
        gy = 2'd0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (adv) begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        hit_r[j]  <= hit_r[j-1];
        par_r[j]  <= par_r[j-1];
        negx_r[j] <= negx_r[j-1];
        negy_r[j] <= negy_r[j-1];
        magx_r[j] <= magx_r[j-1];
        magy_r[j] <= magy_r[j-1];
        num_r[j]  <= num_r[j-1];
        dv_r[j]   <= dv_r[j-1];
        sx_r[j]   <= sx_r[j-1];
        sy_r[j]   <= sy_r[j-1];
        qx_r[j]   <= {qx_r[j-1][QW-2:0], 1'b0} + QW'(gx);
        qy_r[j]   <= {qy_r[j-1][QW-2:0], 1'b0} + QW'(gy);
        rx_r[j]   <= tx - ((gx == 2'd2) ? dd2 : ((gx == 2'd1) ? dd1 : '0));
        ry_r[j]   <= ty - ((gy == 2'd2) ? dd2 : ((gy == 2'd1) ? dd1 : '0));
      end
    end
  end

  // Final add and truncation toward zero.
  logic signed [CW+1:0] vx, vy, fx, fy;

  always_comb begin
    vx = negx_r[NS-1] ? ((CW+2)'($signed(sx_r[NS-1])) - $signed({1'b0, qx_r[NS-1]}))
                      : ((CW+2)'($signed(sx_r[NS-1])) + $signed({1'b0, qx_r[NS-1]}));
    vy = negy_r[NS-1] ? ((CW+2)'($signed(sy_r[NS-1])) - $signed({1'b0, qy_r[NS-1]}))
                      : ((CW+2)'($signed(sy_r[NS-1])) + $signed({1'b0, qy_r[NS-1]}));
    fx = vx;
    fy = vy;
    if (rx_r[NS-1] != '0) begin
      if (negx_r[NS-1] && vx > 0) begin
        fx = vx - (CW+2)'(1);
      end else if (!negx_r[NS-1] && vx < 0) begin
        fx = vx + (CW+2)'(1);
      end
    end
    if (ry_r[NS-1] != '0) begin
      if (negy_r[NS-1] && vy > 0) begin
        fy = vy - (CW+2)'(1);
      end else if (!negy_r[NS-1] && vy < 0) begin
        fy = vy + (CW+2)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r <= hit_r[NS-1];
      out_par_r <= par_r[NS-1];
      out_x_r   <= hit_r[NS-1] ? fx[CW-1:0] : '0;
      out_y_r   <= hit_r[NS-1] ? fy[CW-1:0] : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_parallel = out_par_r;
  assign out_cross_x  = out_x_r;
  assign out_cross_y  = out_y_r;

`ifndef SYNTHESIS
  a_par_no_hit : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_par_r |-> !out_hit_r)
    else $error("parallel result reports a hit");

  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> (out_x_r == '0) && (out_y_r == '0))
    else $error("point not zero without hit");

  a_num_le_den : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] && hit_r[0] |-> (num_r[0] <= dv_r[0]) && (dv_r[0] != '0))
    else $error("hit with numerator above denominator");

  a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-1] && hit_r[NS-1] |-> (rx_r[NS-1] < RW'(dv_r[NS-1]))
      && (ry_r[NS-1] < RW'(dv_r[NS-1])))
    else $error("divider remainder out of range");
`endif

endmodule
